// File: rtl/core/casp_pkg.sv
// Shared types and constants for the client affinity slot pool.
package casp_pkg;

	localparam int unsigned POOL_SLOTS_DEF = 16;
	localparam int unsigned ADDR_W         = 64;
	localparam int unsigned CNT_W          = 32;
	localparam int unsigned TIME_W         = 32;
	localparam int unsigned IDX_IN_W       = 8;
	localparam int unsigned RECL_W         = 9;

	localparam logic [CNT_W-1:0]  COUNT_MAX   = 32'hffff_ffff;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd600;

	typedef logic [2:0] op_t;
	localparam op_t OP_REQUEST = 3'd0;
	localparam op_t OP_RELEASE = 3'd1;
	localparam op_t OP_TAINT   = 3'd2;
	localparam op_t OP_TICK    = 3'd3;
	localparam op_t OP_SWEEP   = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAN_IDLE = 2'd0,
		ST_CLEAN_CONN = 2'd1,
		ST_TAINT_CONN = 2'd2,
		ST_TAINT_IDLE = 2'd3
	} slot_st_t;

	typedef struct packed {
		slot_st_t            state;
		logic [CNT_W-1:0]    count;
		logic [ADDR_W-1:0]   addr_high;
		logic [ADDR_W-1:0]   addr_low;
		logic [TIME_W-1:0]   rel_time;
	} slot_t;

	typedef enum logic [2:0] {
		WR_NONE  = 3'd0,
		WR_HIT   = 3'd1,
		WR_CLAIM = 3'd2,
		WR_REL   = 3'd3,
		WR_TAINT = 3'd4,
		WR_SWEEP = 3'd5
	} wr_kind_t;

	typedef struct packed {
		logic     load;
		logic     tick;
		logic     rd;
		logic     advance;
		logic     note_free;
		wr_kind_t wr;
		logic     set_ok;
		logic     set_fail;
		logic     push;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic idx_ok;
		logic hit;
		logic clean;
		logic free_found;
		logic last;
		logic expired;
		logic rel_ok;
		logic taint_ok;
		logic out_free;
	} ctrl_sts_t;

endpackage

// File: rtl/core/casp_ram.sv
// Generic single-port-write, registered-read RAM.
module casp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/core/casp_ctrl.sv
// Sequencing state machine for the slot pool.
module casp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  casp_pkg::ctrl_sts_t sts,
	output casp_pkg::ctrl_cmd_t cmd
);
	import casp_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_READ   = 6'b000100,
		S_EVAL   = 6'b001000,
		S_CLAIM  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.wr  = WR_NONE;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_TICK: begin
						cmd.tick   = 1'b1;
						cmd.set_ok = 1'b1;
						state_d    = S_DONE;
					end
					OP_REQUEST, OP_SWEEP: begin
						state_d = S_READ;
					end
					OP_RELEASE, OP_TAINT: begin
						if (sts.idx_ok) begin
							state_d = S_READ;
						end else begin
							cmd.set_fail = 1'b1;
							state_d      = S_DONE;
						end
					end
					default: begin
						cmd.set_fail = 1'b1;
						state_d      = S_DONE;
					end
				endcase
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				case (sts.op)
					OP_REQUEST: begin
						if (sts.hit) begin
							cmd.wr     = WR_HIT;
							cmd.set_ok = 1'b1;
							state_d    = S_DONE;
						end else begin
							cmd.note_free = sts.clean && !sts.free_found;
							if (!sts.last) begin
								cmd.advance = 1'b1;
								state_d     = S_READ;
							end else if (sts.free_found || sts.clean) begin
								state_d = S_CLAIM;
							end else begin
								cmd.set_fail = 1'b1;
								state_d      = S_DONE;
							end
						end
					end
					OP_RELEASE: begin
						if (sts.rel_ok) begin
							cmd.wr     = WR_REL;
							cmd.set_ok = 1'b1;
						end else begin
							cmd.set_fail = 1'b1;
						end
						state_d = S_DONE;
					end
					OP_TAINT: begin
						if (sts.taint_ok) begin
							cmd.wr     = WR_TAINT;
							cmd.set_ok = 1'b1;
						end else begin
							cmd.set_fail = 1'b1;
						end
						state_d = S_DONE;
					end
					OP_SWEEP: begin
						if (sts.expired) begin
							cmd.wr = WR_SWEEP;
						end
						if (sts.last) begin
							cmd.set_ok = 1'b1;
							state_d    = S_DONE;
						end else begin
							cmd.advance = 1'b1;
							state_d     = S_READ;
						end
					end
					default: begin
						cmd.set_fail = 1'b1;
						state_d      = S_DONE;
					end
				endcase
			end
			S_CLAIM: begin
				cmd.wr     = WR_CLAIM;
				cmd.set_ok = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> ($past(state_q) == S_READ))
		else $error("evaluation without a preceding read");

	a_claim_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLAIM) |-> ($past(state_q) == S_EVAL) && sts.free_found)
		else $error("claim without a free slot noted");
endmodule

// File: rtl/core/casp_dp.sv
// Slot store, comparators, counters and result register for the slot pool.
module casp_dp #(
	parameter int unsigned POOL_SLOTS = casp_pkg::POOL_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  casp_pkg::ctrl_cmd_t               cmd,
	output casp_pkg::ctrl_sts_t               sts,
	input  casp_pkg::op_t                     in_op,
	input  logic [casp_pkg::ADDR_W-1:0]       in_addr_high,
	input  logic [casp_pkg::ADDR_W-1:0]       in_addr_low,
	input  logic [casp_pkg::IDX_IN_W-1:0]     in_slot_index,
	input  logic                              cfg_we,
	input  logic [casp_pkg::TIME_W-1:0]       cfg_wdata,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_status,
	output logic [casp_pkg::IDX_IN_W-1:0]     out_granted,
	output logic [casp_pkg::RECL_W-1:0]       out_reclaimed
);
	import casp_pkg::*;

	localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int unsigned SLOT_W = $bits(slot_t);

	op_t                 op_q;
	logic [ADDR_W-1:0]   hi_q, lo_q;
	logic [IDX_IN_W-1:0] idx_q;
	logic [IDX_W-1:0]    cursor_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [TIME_W-1:0]   free_rel_q;
	logic                free_found_q;
	logic [TIME_W-1:0]   time_q;
	logic [TIME_W-1:0]   timeout_q;
	logic [POOL_SLOTS-1:0] vld_q;
	logic                rd_vld_q;
	logic                res_status_q;
	logic [IDX_IN_W-1:0] res_granted_q;
	logic [RECL_W-1:0]   res_count_q;
	logic                out_valid_q;
	logic                out_status_q;
	logic [IDX_IN_W-1:0] out_granted_q;
	logic [RECL_W-1:0]   out_count_q;

	logic [SLOT_W-1:0]   rdata;
	slot_t               slot;
	slot_t               wslot;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic                same;
	logic                conn;
	logic [TIME_W-1:0]   idle_time;

	casp_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(POOL_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wslot),
		.re   (cmd.rd),
		.raddr(cursor_q),
		.rdata(rdata)
	);

	assign slot      = rd_vld_q ? slot_t'(rdata) : slot_t'('0);
	assign same      = (slot.addr_high == hi_q) && (slot.addr_low == lo_q);
	assign conn      = (slot.state == ST_CLEAN_CONN) || (slot.state == ST_TAINT_CONN);
	assign idle_time = time_q - slot.rel_time;

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.idx_ok     = ({1'b0, idx_q} < (IDX_IN_W + 1)'(POOL_SLOTS));
		sts.hit        = same && ((conn && (slot.count != COUNT_MAX)) ||
		                          (slot.state == ST_TAINT_IDLE));
		sts.clean      = (slot.state == ST_CLEAN_IDLE);
		sts.free_found = free_found_q;
		sts.last       = (cursor_q == IDX_W'(POOL_SLOTS - 1));
		sts.expired    = (slot.state == ST_TAINT_IDLE) && (idle_time > timeout_q);
		sts.rel_ok     = conn && (slot.count != '0);
		sts.taint_ok   = (slot.state != ST_CLEAN_IDLE);
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		wslot = slot;
		we    = 1'b1;
		waddr = cursor_q;
		case (cmd.wr)
			WR_HIT: begin
				if (slot.state == ST_TAINT_IDLE) begin
					wslot.state = ST_TAINT_CONN;
					wslot.count = CNT_W'(1);
				end else begin
					wslot.count = slot.count + CNT_W'(1);
				end
			end
			WR_CLAIM: begin
				waddr           = free_idx_q;
				wslot.state     = ST_CLEAN_CONN;
				wslot.count     = CNT_W'(1);
				wslot.addr_high = hi_q;
				wslot.addr_low  = lo_q;
				wslot.rel_time  = free_rel_q;
			end
			WR_REL: begin
				wslot.count    = slot.count - CNT_W'(1);
				wslot.rel_time = time_q;
				if (slot.count == CNT_W'(1)) begin
					wslot.state = (slot.state == ST_CLEAN_CONN) ? ST_CLEAN_IDLE
					                                            : ST_TAINT_IDLE;
				end
			end
			WR_TAINT: begin
				wslot.state = ST_TAINT_CONN;
			end
			WR_SWEEP: begin
				wslot.state = ST_CLEAN_IDLE;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			hi_q  <= in_addr_high;
			lo_q  <= in_addr_low;
			idx_q <= in_slot_index;
		end
		if (cmd.note_free) begin
			free_idx_q <= cursor_q;
			free_rel_q <= slot.rel_time;
		end
		if (cmd.push) begin
			out_status_q  <= res_status_q;
			out_granted_q <= res_granted_q;
			out_count_q   <= res_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q      <= '0;
			free_found_q  <= 1'b0;
			time_q        <= '0;
			timeout_q     <= TIMEOUT_RST;
			vld_q         <= '0;
			rd_vld_q      <= 1'b0;
			res_status_q  <= 1'b0;
			res_granted_q <= '0;
			res_count_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (cmd.tick) begin
				time_q <= time_q + TIME_W'(1);
			end
			if (cmd.load) begin
				cursor_q      <= ((in_op == OP_RELEASE) || (in_op == OP_TAINT)) ?
				                 in_slot_index[IDX_W-1:0] : '0;
				free_found_q  <= 1'b0;
				res_status_q  <= 1'b0;
				res_granted_q <= '0;
				res_count_q   <= '0;
			end else if (cmd.advance) begin
				cursor_q <= cursor_q + IDX_W'(1);
			end
			if (cmd.note_free) begin
				free_found_q <= 1'b1;
			end
			if (cmd.rd) begin
				rd_vld_q <= vld_q[cursor_q];
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (cmd.wr == WR_HIT) begin
				res_granted_q <= IDX_IN_W'(cursor_q);
			end else if (cmd.wr == WR_CLAIM) begin
				res_granted_q <= IDX_IN_W'(free_idx_q);
			end
			if (cmd.wr == WR_SWEEP) begin
				res_count_q <= res_count_q + RECL_W'(1);
			end
			if (cmd.set_ok) begin
				res_status_q <= 1'b0;
			end else if (cmd.set_fail) begin
				res_status_q <= 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_status    = out_status_q;
	assign out_granted   = out_granted_q;
	assign out_reclaimed = out_count_q;

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result pushed over an untaken word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_count_q <= RECL_W'(POOL_SLOTS))
		else $error("reclaimed count beyond pool size");

	a_grant_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr == WR_HIT || cmd.wr == WR_CLAIM) |=> res_granted_q < IDX_IN_W'(POOL_SLOTS)
		|| POOL_SLOTS > 255)
		else $error("granted slot beyond pool size");
endmodule

// File: rtl/core/client_affinity_slot_pool_core.sv
// Top level of the client affinity slot pool.
//
// Input words arrive on the s_ stream, one operation each: request, release,
// mark tainted, tick or sweep. Every input word yields exactly one result word
// on the m_ stream with status, granted slot and reclaimed count.
// The pool is walked one slot at a time through a single slot RAM with a
// registered read: each slot is read in S_READ and evaluated in S_EVAL.
// A request walks the pool until a hit or the last slot, then goes through
// S_CLAIM when a clean slot is claimed; a sweep walks every slot; release
// and mark tainted read at most the indexed slot; tick and unknown operations
// read no slot. s_tready returns once the result has been pushed.
// Reset clears all slots to clean idle with zero contents, time to zero and
// the idle timeout to 600; no clearing pass is needed.
// The result sits in an output register; the next word is accepted and
// processed while it waits, and that word's result is held back until
// m_tready takes the earlier one.
// cfg_we writes the idle timeout; write it only while the block is idle.
module client_affinity_slot_pool_core #(
	parameter int unsigned POOL_SLOTS = casp_pkg::POOL_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// operation[2:0], client_addr_high[66:3], client_addr_low[130:67],
	// slot_index[138:131], zero fill
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[0], granted_slot[8:1], reclaimed_count[17:9], zero fill
	output logic [23:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);
	import casp_pkg::*;

	ctrl_cmd_t           cmd;
	ctrl_sts_t           sts;
	logic                out_status;
	logic [IDX_IN_W-1:0] out_granted;
	logic [RECL_W-1:0]   out_reclaimed;

	casp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	casp_dp #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_op        (s_tdata[2:0]),
		.in_addr_high (s_tdata[66:3]),
		.in_addr_low  (s_tdata[130:67]),
		.in_slot_index(s_tdata[138:131]),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_status   (out_status),
		.out_granted  (out_granted),
		.out_reclaimed(out_reclaimed)
	);

	assign m_tdata = {6'd0, out_reclaimed, out_granted, out_status};
endmodule
